/* rtl/dfn_pkg.sv */
`timescale 1ns / 1ps

package dfn_pkg;

    localparam int MAX_ITEMS_DEF  = 16;
    localparam int COORD_BITS_DEF = 16;

    localparam int OPC_W  = 2;
    localparam int IDX_W  = 4;
    localparam int DIR_W  = 2;
    localparam int STEP_W = 6;
    localparam int CNT_W  = 5;
    localparam int MOD_W  = 7;
    localparam int OUT_W  = 8;

    // minimum lead along the direction, at twice scale
    localparam int MIN_PROJ = 4;

    localparam logic [OPC_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OPC_W-1:0] OP_MOVE = 2'd1;
    localparam logic [OPC_W-1:0] OP_SET  = 2'd2;
    localparam logic [OPC_W-1:0] OP_STEP = 2'd3;

    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic             clear;
        logic             base_load;
        logic             in_valid;
        logic [CNT_W-1:0] in_idx;
        logic [CNT_W-1:0] cur_idx;
        logic [DIR_W-1:0] dir;
    } scan_ctrl_t;

    typedef struct packed {
        logic             busy;
        logic             found;
        logic [CNT_W-1:0] best_idx;
    } scan_stat_t;

endpackage

/* rtl/dfn_item_mem.sv */
`timescale 1ns / 1ps

module dfn_item_mem #(
    parameter int DEPTH = 16,
    parameter int DW    = 37,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/dfn_scan.sv */
`timescale 1ns / 1ps

module dfn_scan #(
    parameter int COORD_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dfn_pkg::scan_ctrl_t       ctrl,
    input  logic [2*(COORD_BITS+2):0] rd_data,
    output dfn_pkg::scan_stat_t       stat
);

    import dfn_pkg::*;

    localparam int CW = COORD_BITS + 2;
    localparam int DW = CW + 1;
    localparam int PW = CW + 2;
    localparam int SW = CW + 3;

    logic signed [CW-1:0] base_cx_reg;
    logic signed [CW-1:0] base_cy_reg;
    logic signed [CW-1:0] cand_cx;
    logic signed [CW-1:0] cand_cy;
    logic                 cand_placed;

    logic                 s1_valid_reg;
    logic                 s1_ok_reg;
    logic [CNT_W-1:0]     s1_idx_reg;
    logic signed [DW-1:0] s1_dx_reg;
    logic signed [DW-1:0] s1_dy_reg;

    logic signed [PW-1:0] dxe;
    logic signed [PW-1:0] dye;
    logic signed [PW-1:0] proj;
    logic signed [PW-1:0] perp_s;
    logic                 s2_valid_reg;
    logic                 s2_ok_reg;
    logic [CNT_W-1:0]     s2_idx_reg;
    logic [PW-2:0]        s2_proj_reg;
    logic [PW-2:0]        s2_perp_reg;

    logic [SW-1:0]        score;
    logic                 s3_valid_reg;
    logic                 s3_ok_reg;
    logic [CNT_W-1:0]     s3_idx_reg;
    logic [SW-1:0]        s3_score_reg;

    logic                 found_reg;
    logic [CNT_W-1:0]     best_idx_reg;
    logic [SW-1:0]        best_score_reg;

    assign cand_cx     = rd_data[CW-1:0];
    assign cand_cy     = rd_data[2*CW-1:CW];
    assign cand_placed = rd_data[2*CW];

    always_ff @(posedge clk)
    begin
        if (ctrl.base_load)
        begin
            base_cx_reg <= cand_cx;
            base_cy_reg <= cand_cy;
        end
    end

    // stage 1: centre differences
    always_ff @(posedge clk)
    begin
        s1_idx_reg <= ctrl.in_idx;
        s1_ok_reg  <= cand_placed && (ctrl.in_idx != ctrl.cur_idx);
        s1_dx_reg  <= DW'(cand_cx) - DW'(base_cx_reg);
        s1_dy_reg  <= DW'(cand_cy) - DW'(base_cy_reg);
    end

    // stage 2: projection and perpendicular offset
    always_comb
    begin
        dxe = PW'(s1_dx_reg);
        dye = PW'(s1_dy_reg);
        case (ctrl.dir)
            DIR_UP:
            begin
                proj   = -dye;
                perp_s = (dxe < 0) ? -dxe : dxe;
            end
            DIR_DOWN:
            begin
                proj   = dye;
                perp_s = (dxe < 0) ? -dxe : dxe;
            end
            DIR_LEFT:
            begin
                proj   = -dxe;
                perp_s = (dye < 0) ? -dye : dye;
            end
            default:
            begin
                proj   = dxe;
                perp_s = (dye < 0) ? -dye : dye;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s2_idx_reg  <= s1_idx_reg;
        s2_ok_reg   <= s1_ok_reg && (proj >= PW'(MIN_PROJ));
        s2_proj_reg <= proj[PW-2:0];
        s2_perp_reg <= perp_s[PW-2:0];
    end

    // stage 3: score
    assign score = SW'(s2_proj_reg) + SW'({s2_perp_reg, 1'b0}) + SW'(s2_perp_reg);

    always_ff @(posedge clk)
    begin
        s3_idx_reg   <= s2_idx_reg;
        s3_ok_reg    <= s2_ok_reg;
        s3_score_reg <= score;
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && s3_ok_reg && (!found_reg || (s3_score_reg < best_score_reg)))
        begin
            best_idx_reg   <= s3_idx_reg;
            best_score_reg <= s3_score_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctrl.in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (ctrl.clear)
            begin
                found_reg <= 1'b0;
            end
            else if (s3_valid_reg && s3_ok_reg)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    assign stat.busy     = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign stat.found    = found_reg;
    assign stat.best_idx = best_idx_reg;

endmodule

/* rtl/dfn_mod.sv */
`timescale 1ns / 1ps

module dfn_mod (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [dfn_pkg::MOD_W-1:0]   sum,
    input  logic [dfn_pkg::CNT_W-1:0]          n,
    input  logic                               ack,
    output logic                               done,
    output logic [dfn_pkg::CNT_W-1:0]          result
);

    import dfn_pkg::*;

    logic                    busy_reg;
    logic signed [MOD_W-1:0] val_reg;
    logic signed [MOD_W-1:0] n_s;
    logic                    neg;
    logic                    over;

    assign n_s  = $signed(MOD_W'(n));
    assign neg  = val_reg < 0;
    assign over = !neg && (val_reg >= n_s);
    assign done = busy_reg && !neg && !over;
    assign result = val_reg[CNT_W-1:0];

    // one add or subtract of the modulus per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= sum;
        end
        else if (busy_reg && neg)
        begin
            val_reg <= val_reg + n_s;
        end
        else if (busy_reg && over)
        begin
            val_reg <= val_reg - n_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done && ack)
        begin
            busy_reg <= 1'b0;
        end
    end

endmodule

/* rtl/directional_focus_navigation_core.sv */
`timescale 1ns / 1ps

// directional focus navigator
// input channel s_axis: one transaction per command; tuser carries the opcode
// (load item, directional move, set index, linear step), tdata the operands
// output channel m_axis: exactly one result transaction per command, in order
// cfg_we/cfg_wdata: writes item_count, saturated to MAX_ITEMS; write it only
// while no command is in flight
// load and set give their result on the cycle after acceptance
// a directional move reads the focused entry, then every entry in use from the
// single read port of the item memory, one per cycle, through a three-stage
// scoring pipeline
// a linear step runs a modulo unit that adds or subtracts item_count once per
// cycle until index plus step lies within range
// one command is worked at a time; the next is accepted when the result
// register is free or being emptied in the same cycle
// reset clears focus, item_count and all handshake state; item memory contents
// are undefined until loaded
// a stalled receiver holds the result in the output register and blocks new
// commands once the register is full

module directional_focus_navigation_core #(
    parameter int MAX_ITEMS  = dfn_pkg::MAX_ITEMS_DEF,
    parameter int COORD_BITS = dfn_pkg::COORD_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // item_index, pos_x, pos_y, item_width, item_height, direction, linear_step
    input  logic [((4*COORD_BITS+17)/8)*8-1:0]      s_axis_tdata,
    // opcode
    input  logic [dfn_pkg::OPC_W-1:0]               s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // focus_index, focus_valid, moved
    output logic [dfn_pkg::OUT_W-1:0]               m_axis_tdata,
    input  logic                                    cfg_we,
    input  logic [dfn_pkg::CNT_W-1:0]               cfg_wdata
);

    import dfn_pkg::*;

    localparam int C        = COORD_BITS;
    localparam int CW       = C + 2;
    localparam int EW       = 2 * CW + 1;
    localparam int AW       = $clog2(MAX_ITEMS);
    localparam int OFF_PX   = IDX_W;
    localparam int OFF_PY   = OFF_PX + C;
    localparam int OFF_W    = OFF_PY + C;
    localparam int OFF_H    = OFF_W + C - 1;
    localparam int OFF_DIR  = OFF_H + C - 1;
    localparam int OFF_STEP = OFF_DIR + DIR_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BASE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        focus_reg, focus_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        scan_idx_reg, scan_idx_next;
    logic [DIR_W-1:0]        dir_reg, dir_next;
    logic                    rd_valid_reg;
    logic [CNT_W-1:0]        rd_idx_reg;
    logic                    m_valid_reg;
    logic [OUT_W-1:0]        m_data_reg;

    logic                    out_free;
    logic                    in_fire;
    logic                    out_load;
    logic [OUT_W-1:0]        out_data;
    logic                    out_has_focus;

    logic [IDX_W-1:0]        in_idx;
    logic signed [C-1:0]     in_px;
    logic signed [C-1:0]     in_py;
    logic [C-2:0]            in_w;
    logic [C-2:0]            in_h;
    logic [DIR_W-1:0]        in_dir;
    logic signed [STEP_W-1:0] in_step;

    logic [CNT_W-1:0]        cfg_sat;
    logic [CNT_W-1:0]        count_m1;
    logic                    mem_we;
    logic [CW-1:0]           ld_cx;
    logic [CW-1:0]           ld_cy;
    logic [EW-1:0]           ld_entry;
    logic [AW-1:0]           mem_raddr;
    logic [EW-1:0]           mem_rdata;

    scan_ctrl_t              scan_ctrl;
    scan_stat_t              scan_stat;
    logic                    scan_clear;
    logic                    scan_base;

    logic                    mod_start;
    logic                    mod_ack;
    logic                    mod_done;
    logic [CNT_W-1:0]        mod_result;
    logic signed [MOD_W-1:0] mod_sum;

    assign in_idx  = s_axis_tdata[IDX_W-1:0];
    assign in_px   = s_axis_tdata[OFF_PX +: C];
    assign in_py   = s_axis_tdata[OFF_PY +: C];
    assign in_w    = s_axis_tdata[OFF_W +: C-1];
    assign in_h    = s_axis_tdata[OFF_H +: C-1];
    assign in_dir  = s_axis_tdata[OFF_DIR +: DIR_W];
    assign in_step = s_axis_tdata[OFF_STEP +: STEP_W];

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign cfg_sat  = (32'(cfg_wdata) > MAX_ITEMS) ? CNT_W'(MAX_ITEMS) : cfg_wdata;
    assign count_m1 = count_reg - CNT_W'(1);

    // centres at twice scale
    assign ld_cx    = (CW'(in_px) << 1) + CW'(in_w);
    assign ld_cy    = (CW'(in_py) << 1) + CW'(in_h);
    assign ld_entry = {(in_w != '0) && (in_h != '0), ld_cy, ld_cx};

    assign mem_raddr = (state_reg == S_SCAN) ? AW'(scan_idx_reg) : AW'(focus_reg);
    assign mod_sum   = MOD_W'(in_step) + $signed(MOD_W'(focus_reg));
    assign mod_ack   = (state_reg == S_MOD) && out_free;

    always_comb
    begin
        state_next    = state_reg;
        focus_next    = focus_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        dir_next      = dir_reg;
        out_load      = 1'b0;
        mem_we        = 1'b0;
        scan_clear    = 1'b0;
        scan_base     = 1'b0;
        mod_start     = 1'b0;

        if (cfg_we)
        begin
            count_next = cfg_sat;
            if (focus_reg >= cfg_sat)
            begin
                focus_next = '0;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (s_axis_tuser)
                        OP_LOAD:
                        begin
                            mem_we   = 32'(in_idx) < MAX_ITEMS;
                            out_load = 1'b1;
                        end
                        OP_MOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load = 1'b1;
                            end
                            else
                            begin
                                dir_next   = in_dir;
                                state_next = S_BASE;
                            end
                        end
                        OP_SET:
                        begin
                            if (count_reg != '0)
                            begin
                                focus_next = ({1'b0, in_idx} > count_m1) ? count_m1
                                                                         : {1'b0, in_idx};
                            end
                            out_load = 1'b1;
                        end
                        OP_STEP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load = 1'b1;
                            end
                            else
                            begin
                                mod_start  = 1'b1;
                                state_next = S_MOD;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_BASE:
            begin
                scan_base     = 1'b1;
                scan_clear    = 1'b1;
                scan_idx_next = '0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                scan_idx_next = scan_idx_reg + CNT_W'(1);
                if (scan_idx_reg == count_m1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_valid_reg && !scan_stat.busy && out_free)
                begin
                    if (scan_stat.found)
                    begin
                        focus_next = scan_stat.best_idx;
                    end
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MOD:
            begin
                if (mod_done && out_free)
                begin
                    focus_next = mod_result;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_has_focus = count_reg != '0;
    assign out_data = {2'b00, focus_next != focus_reg, out_has_focus,
                       out_has_focus ? focus_next[IDX_W-1:0] : IDX_W'(0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            focus_reg    <= '0;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            focus_reg    <= focus_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            rd_valid_reg <= state_reg == S_SCAN;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg    <= dir_next;
        rd_idx_reg <= scan_idx_reg;
        if (out_load)
        begin
            m_data_reg <= out_data;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign scan_ctrl.clear     = scan_clear;
    assign scan_ctrl.base_load = scan_base;
    assign scan_ctrl.in_valid  = rd_valid_reg;
    assign scan_ctrl.in_idx    = rd_idx_reg;
    assign scan_ctrl.cur_idx   = focus_reg;
    assign scan_ctrl.dir       = dir_reg;

    dfn_item_mem #(
        .DEPTH (MAX_ITEMS),
        .DW    (EW),
        .AW    (AW)
    ) u_item_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(in_idx)),
        .wdata (ld_entry),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dfn_scan #(
        .COORD_BITS (COORD_BITS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (scan_ctrl),
        .rd_data (mem_rdata),
        .stat    (scan_stat)
    );

    dfn_mod u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .sum    (mod_sum),
        .n      (count_reg),
        .ack    (mod_ack),
        .done   (mod_done),
        .result (mod_result)
    );

`ifndef SYNTHESIS
    a_focus_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (focus_reg < count_reg))
        else $error("focus index not below item count");

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == S_IDLE))
        else $error("command accepted while busy");

    a_moved_needs_focus: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[IDX_W+1]) |-> m_data_reg[IDX_W])
        else $error("move reported with empty table");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_idx_reg < count_reg))
        else $error("scan index beyond item count");

    a_move_focus_held: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && $past(state_reg == S_SCAN)) |-> $stable(focus_reg))
        else $error("focus changed during scan");
`endif

endmodule
